### rtl/assert_macros.svh
// Assertion macros shared by the RTL. All of them sample on clk and are
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SNP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define SNP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SNP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SNP_ASSERT(lbl, expr)
`define SNP_ASSERT_IMP(lbl, ante, cons)
`define SNP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/snp_pkg.sv
package snp_pkg;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [3:0] TABS_RST = 4'd9;

  localparam logic SEL_SEQ  = 1'b0;
  localparam logic SEL_NAME = 1'b1;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } snp_item_t;

  typedef struct packed {
    logic       sel;
    logic [7:0] ch;
    logic       last;
  } snp_res_t;

  typedef struct packed {
    logic [1:0] n;
    snp_res_t   r0;
    snp_res_t   r1;
  } snp_batch_t;

endpackage

### rtl/snp_in_reg.sv
module snp_in_reg import snp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [7:0] in_tdata,
  input  logic      in_tlast,
  input  logic      advance,
  output logic      item_valid,
  output snp_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  snp_item_t item_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tvalid || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{ch: in_tdata, eoi: in_tlast};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/snp_parser.sv
`include "assert_macros.svh"

module snp_parser import snp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  snp_item_t  item,
  input  logic       advance,
  output snp_batch_t batch
);

  typedef enum logic [6:0] {
    PH_HDR_CHECK = 7'b0000001,
    PH_HDR_SKIP  = 7'b0000010,
    PH_REC_START = 7'b0000100,
    PH_NAME      = 7'b0001000,
    PH_TABS      = 7'b0010000,
    PH_SEQ       = 7'b0100000,
    PH_REST      = 7'b1000000
  } phase_t;

  logic [3:0] tabs_r;
  phase_t     phase_r, phase_nxt;
  logic [3:0] tab_count_r, tab_count_nxt;
  logic [3:0] held_r, held_nxt;
  logic       pending_r, pending_nxt;
  logic       seen_r, seen_nxt;

  logic       nl_v, main_v, flush_v;
  snp_res_t   main_res, nl_res, flush_res;
  logic [3:0] tab_inc;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tabs_r <= TABS_RST;
    end else if (cfg_wr_en) begin
      tabs_r <= cfg_wr_data;
    end
  end

  assign tab_inc = tab_count_r + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    tab_count_nxt = tab_count_r;
    held_nxt      = held_r;
    pending_nxt   = pending_r;
    seen_nxt      = seen_r;
    nl_v          = 1'b0;
    main_v        = 1'b0;
    main_res      = '{sel: SEL_SEQ, ch: CH_NUL, last: 1'b0};
    nl_res        = '{sel: SEL_SEQ, ch: CH_NL, last: 1'b0};

    case (phase_r)
      PH_HDR_CHECK, PH_REC_START: begin
        if (phase_r == PH_HDR_CHECK && item.ch == CH_AT) begin
          phase_nxt = PH_HDR_SKIP;
        end else begin
          nl_v     = seen_r;
          seen_nxt = 1'b1;
          main_v   = 1'b1;
          if (item.ch == CH_TAB) begin
            main_res      = '{sel: SEL_NAME, ch: CH_NUL, last: 1'b0};
            tab_count_nxt = 4'd1;
            phase_nxt     = (4'd1 >= tabs_r) ? PH_SEQ : PH_TABS;
          end else begin
            main_res  = '{sel: SEL_NAME, ch: item.ch, last: 1'b0};
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_HDR_SKIP: begin
        if (item.ch == CH_NL) begin
          phase_nxt = PH_HDR_CHECK;
        end
      end
      PH_NAME: begin
        main_v = 1'b1;
        if (item.ch == CH_TAB) begin
          main_res      = '{sel: SEL_NAME, ch: CH_NUL, last: 1'b0};
          tab_count_nxt = 4'd1;
          phase_nxt     = (4'd1 >= tabs_r) ? PH_SEQ : PH_TABS;
        end else begin
          main_res = '{sel: SEL_NAME, ch: item.ch, last: 1'b0};
        end
      end
      PH_TABS: begin
        if (item.ch == CH_TAB) begin
          tab_count_nxt = tab_inc;
          if (tab_inc >= tabs_r) begin
            phase_nxt = PH_SEQ;
          end
        end
      end
      PH_SEQ: begin
        if (item.ch == CH_TAB) begin
          main_v      = pending_r;
          main_res    = '{sel: SEL_SEQ, ch: {held_r, 4'h0}, last: 1'b0};
          pending_nxt = 1'b0;
          held_nxt    = 4'h0;
          phase_nxt   = PH_REST;
        end else if (pending_r) begin
          main_v      = 1'b1;
          main_res    = '{sel: SEL_SEQ, ch: {held_r, item.ch[3:0]}, last: 1'b0};
          pending_nxt = 1'b0;
          held_nxt    = 4'h0;
        end else begin
          held_nxt    = item.ch[3:0];
          pending_nxt = 1'b1;
        end
      end
      PH_REST: begin
        if (item.ch == CH_NL) begin
          phase_nxt = PH_REC_START;
        end
      end
      default: begin
        phase_nxt = PH_HDR_CHECK;
      end
    endcase

    flush_v   = item.eoi && pending_nxt;
    flush_res = '{sel: SEL_SEQ, ch: {held_nxt, 4'h0}, last: 1'b0};

    if (item.eoi) begin
      phase_nxt     = PH_HDR_CHECK;
      tab_count_nxt = 4'd0;
      held_nxt      = 4'h0;
      pending_nxt   = 1'b0;
      seen_nxt      = 1'b0;
    end
  end

  // At most two of the three candidates are ever present.
  assign cnt = {1'b0, nl_v} + {1'b0, main_v} + {1'b0, flush_v};

  always_comb begin
    batch.n  = cnt;
    batch.r0 = nl_v ? nl_res : (main_v ? main_res : flush_res);
    batch.r1 = (nl_v && main_v) ? main_res : flush_res;
    batch.r0.last = (cnt == 2'd1);
    batch.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR_CHECK;
      tab_count_r <= 4'd0;
      held_r      <= 4'h0;
      pending_r   <= 1'b0;
      seen_r      <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      tab_count_r <= tab_count_nxt;
      held_r      <= held_nxt;
      pending_r   <= pending_nxt;
      seen_r      <= seen_nxt;
    end
  end

  `SNP_ASSERT_IMP(a_pending_in_seq, pending_r, phase_r == PH_SEQ)

endmodule

### rtl/snp_out_buf.sv
`include "assert_macros.svh"

module snp_out_buf import snp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  snp_batch_t batch,
  output logic       advance,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  logic [1:0] cnt_r, cnt_nxt;
  snp_res_t   head_r, head_nxt;
  snp_res_t   tail_r, tail_nxt;
  logic       pop;
  logic [1:0] cnt_pop;

  assign pop     = out_tvalid && out_tready;
  assign cnt_pop = cnt_r - {1'b0, pop};
  assign advance = item_valid && (cnt_pop == 2'd0);

  always_comb begin
    cnt_nxt  = cnt_pop;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (advance) begin
      cnt_nxt  = batch.n;
      head_nxt = batch.r0;
      tail_nxt = batch.r1;
    end else if (pop) begin
      head_nxt = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head_r.ch;
  assign out_tuser  = head_r.sel;
  assign out_tlast  = head_r.last;

  `SNP_ASSERT(a_cnt_range, cnt_r != 2'd3)
  `SNP_ASSERT_IMP(a_no_overwrite, advance, cnt_pop == 2'd0)
  `SNP_ASSERT_NXT(a_drain_one, pop && cnt_r == 2'd2 && !advance, cnt_r == 2'd1)
  `SNP_ASSERT_IMP(a_last_when_single, out_tvalid && cnt_r == 2'd1, out_tlast)

endmodule

### rtl/sam_sequence_nibble_packer.sv
// SAM sequence nibble packer.
// The input channel carries one byte of SAM text per transaction in in_tdata,
// with in_tlast marking the final byte of the file. Header lines starting with
// '@' at the start of the file are skipped. Each read name goes out with
// out_tuser high, ended by a zero byte; the sequence field goes out with
// out_tuser low, packed two characters per byte (first in the high nibble).
// A newline separator precedes every record after the first. out_tlast marks
// the last result caused by one input byte; bytes may cause none.
// cfg_wr_en writes cfg_wr_data as the number of tabs before the sequence
// field; write it only while the block is idle.
// An accepted byte waits in the input register and is parsed combinationally;
// its results are registered in the result buffer. One byte is taken per cycle
// while each byte yields at most one result and the receiver keeps up; a byte
// with two results waits, as the buffer must drain before the next byte is parsed.
// A stalled receiver fills the result buffer and then the input register,
// after which in_tready drops. Synchronous reset clears the parser to the
// start-of-file state and sets the tab count to nine.
module sam_sequence_nibble_packer import snp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tuser,  // [0] stream_sel
  output logic       out_tlast
);

  logic       item_valid;
  snp_item_t  item;
  logic       advance;
  snp_batch_t batch;

  snp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  snp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .advance     (advance),
    .batch       (batch)
  );

  snp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .batch      (batch),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import snp_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 7;
  localparam int TARGET_ITEMS = 1750;
  localparam int PHASE_ITEMS = 180;
  localparam int MAX_GAP = 14;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_PHASE = 4;

  typedef enum logic [2:0] {
    PS_HDR_CHECK,
    PS_HDR_SKIP,
    PS_REC_START,
    PS_NAME,
    PS_TABS,
    PS_SEQ,
    PS_REST
  } parse_state_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;  // [7:0] in_char
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;        // [7:0] out_char
  logic       out_tuser;        // [0] stream_sel
  logic       out_tlast;

  snp_item_t  text_queue[$];
  snp_res_t   expected_bytes[$];
  snp_res_t   step_res[$];
  logic [7:0] file_bytes[$];

  parse_state_t pk_state;
  logic [3:0]   pk_tab_count;
  logic [3:0]   pk_held;
  logic [3:0]   pk_tabs_cfg;
  logic         pk_pending;
  logic         pk_seen;

  logic in_accepted = 1'b0;
  logic out_accepted = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   in_gap_max = 0;
  int   out_gap_max = 0;
  int   rx_hold = 0;
  int   quiet_cycles = 0;
  int   mismatch_count = 0;
  int   queued_total = 0;

  sam_sequence_nibble_packer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic void emit_result(input logic sel, input logic [7:0] ch);
    snp_res_t r;
    r.sel = sel;
    r.ch = ch;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void clear_parser();
    pk_state = PS_HDR_CHECK;
    pk_tab_count = 4'd0;
    pk_held = 4'd0;
    pk_pending = 1'b0;
    pk_seen = 1'b0;
  endfunction

  // The tab that ends the name is the first one counted.
  function automatic void enter_tab_run();
    pk_tab_count = 4'd1;
    pk_state = (pk_tab_count >= pk_tabs_cfg) ? PS_SEQ : PS_TABS;
  endfunction

  task automatic pack_text_byte(input logic [7:0] c, input logic eoi);
    step_res.delete();
    case (pk_state)
      PS_HDR_CHECK, PS_REC_START: begin
        if (pk_state == PS_HDR_CHECK && c == CH_AT) begin
          pk_state = PS_HDR_SKIP;
        end else begin
          if (pk_seen) emit_result(SEL_SEQ, CH_NL);
          pk_seen = 1'b1;
          if (c == CH_TAB) begin
            emit_result(SEL_NAME, CH_NUL);
            enter_tab_run();
          end else begin
            emit_result(SEL_NAME, c);
            pk_state = PS_NAME;
          end
        end
      end
      PS_HDR_SKIP: begin
        if (c == CH_NL) pk_state = PS_HDR_CHECK;
      end
      PS_NAME: begin
        if (c == CH_TAB) begin
          emit_result(SEL_NAME, CH_NUL);
          enter_tab_run();
        end else begin
          emit_result(SEL_NAME, c);
        end
      end
      PS_TABS: begin
        if (c == CH_TAB) begin
          pk_tab_count = pk_tab_count + 4'd1;
          if (pk_tab_count >= pk_tabs_cfg) pk_state = PS_SEQ;
        end
      end
      PS_SEQ: begin
        if (c == CH_TAB) begin
          if (pk_pending) emit_result(SEL_SEQ, {pk_held, 4'h0});
          pk_pending = 1'b0;
          pk_held = 4'd0;
          pk_state = PS_REST;
        end else if (pk_pending) begin
          emit_result(SEL_SEQ, {pk_held, c[3:0]});
          pk_pending = 1'b0;
          pk_held = 4'd0;
        end else begin
          pk_held = c[3:0];
          pk_pending = 1'b1;
        end
      end
      PS_REST: begin
        if (c == CH_NL) pk_state = PS_REC_START;
      end
      default: begin
        pk_state = PS_HDR_CHECK;
      end
    endcase
    if (eoi) begin
      if (pk_pending) emit_result(SEL_SEQ, {pk_held, 4'h0});
      clear_parser();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_bytes.push_back(step_res[i]);
  endtask

  always @(posedge clk) begin
    snp_res_t want;
    if (!rst_n) begin
      clear_parser();
      pk_tabs_cfg = TABS_RST;
      in_accepted <= 1'b0;
      out_accepted <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_wr_en) pk_tabs_cfg = cfg_wr_data;
      in_accepted <= in_tvalid && in_tready;
      out_accepted <= out_tvalid && out_tready;
      quiet_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                      0 : quiet_cycles + 1;
      if (in_tvalid && in_tready) pack_text_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected result sel=%0b char=%02h last=%0b",
                                  out_tuser, out_tdata, out_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (out_tuser !== want.sel)
            note_mismatch($sformatf("stream_sel got %0b, want %0b", out_tuser, want.sel));
          if (out_tdata !== want.ch)
            note_mismatch($sformatf("out_char got %02h, want %02h", out_tdata, want.ch));
          if (out_tlast !== want.last)
            note_mismatch($sformatf("run_last got %0b, want %0b", out_tlast, want.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    snp_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_accepted) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (text_queue.size() > 0) begin
        item = text_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= item.ch;
        in_tlast <= item.eoi;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_accepted) out_gap = $urandom_range(0, out_gap_max);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] any_byte_but(input logic [7:0] banned);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == banned);
    return b;
  endfunction

  function automatic logic [7:0] base_char();
    logic [7:0] bases [5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E};
    if ($urandom_range(0, 4) == 0) return any_byte_but(CH_TAB);
    return bases[$urandom_range(0, 4)];
  endfunction

  task automatic send_file();
    snp_item_t item;
    foreach (file_bytes[i]) begin
      item.ch = file_bytes[i];
      item.eoi = (i == file_bytes.size() - 1);
      text_queue.push_back(item);
    end
    queued_total += file_bytes.size();
    file_bytes.delete();
  endtask

  // Mostly well-formed files with random content; some are cut short and
  // some are plain noise.
  task automatic add_file(input logic [3:0] tabs);
    int len;
    int field_tabs;
    field_tabs = (tabs == 4'd0) ? 1 : tabs;
    file_bytes.delete();
    if ($urandom_range(0, 6) == 0) begin
      len = $urandom_range(3, 40);
      repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        file_bytes.push_back(CH_AT);
        repeat ($urandom_range(0, 5)) file_bytes.push_back(any_byte_but(CH_NL));
        file_bytes.push_back(CH_NL);
      end
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 6)) file_bytes.push_back(any_byte_but(CH_TAB));
        file_bytes.push_back(CH_TAB);
        repeat (field_tabs - 1) begin
          repeat ($urandom_range(0, 3)) file_bytes.push_back(any_byte_but(CH_TAB));
          file_bytes.push_back(CH_TAB);
        end
        repeat ($urandom_range(0, 13)) file_bytes.push_back(base_char());
        file_bytes.push_back(CH_TAB);
        repeat ($urandom_range(0, 8)) file_bytes.push_back(any_byte_but(CH_NL));
        file_bytes.push_back(CH_NL);
      end
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > len) void'(file_bytes.pop_back());
      end
    end
    send_file();
  endtask

  task automatic wait_until_drained();
    do @(posedge clk); while (text_queue.size() > 0 || in_tvalid || expected_bytes.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic drain_and_configure(input logic [3:0] tabs);
    wait_until_drained();
    @(negedge clk);
    cfg_wr_data <= tabs;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [3:0] tab_plan[$] = '{4'd15, 4'd1, 4'd0, 4'd9, 4'd4, 4'd2, 4'd15};
    logic [3:0] tabs;
    int phase_num;
    int phase_start;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header line, name extremes, reset tab count, file ending on a held nibble.
    file_bytes = '{CH_AT, 8'h68, CH_NL, CH_NUL, 8'hFF};
    repeat (9) file_bytes.push_back(CH_TAB);
    file_bytes.push_back(8'h41);
    send_file();

    // Zero tab count, empty name, newline inside the sequence, odd length,
    // and an '@' that starts a record rather than a header.
    drain_and_configure(4'd0);
    file_bytes = '{CH_TAB, CH_NL, 8'h43, 8'h41, CH_TAB, 8'h72, CH_NL,
                   CH_AT, CH_TAB, 8'h47, 8'h54, CH_TAB};
    send_file();

    phase_num = 0;
    while (queued_total < TARGET_ITEMS) begin
      tabs = (phase_num < tab_plan.size()) ? tab_plan[phase_num] :
             4'($urandom_range(0, 15));
      drain_and_configure(tabs);
      in_gap_max = (phase_num % 3 == 1 || phase_num == PRESSURE_PHASE) ? 0 : MAX_GAP;
      out_gap_max = (phase_num % 4 == 2) ? 0 : MAX_GAP;
      if (phase_num == PRESSURE_PHASE) rx_hold = LONG_HOLD;
      phase_start = queued_total;
      while (queued_total - phase_start < PHASE_ITEMS) add_file(tabs);
      phase_num++;
    end

    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
